// File: src/frtt_pkg.sv
// shared codes, default sizes and the match unit flag group of the fault rule table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frtt_pkg;

    // operation codes carried in the input tuser field
    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_CLEAR    = 2'd1;
    localparam logic [1:0] FUNC_CHECK    = 2'd2;

    // default table geometry
    localparam int RULES_DEF      = 16;
    localparam int POINT_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF = 32;

    // fixed field widths of the stream words
    localparam int IN_DATA_BITS  = 72;
    localparam int OUT_DATA_BITS = 40;
    localparam int TOTAL_BITS    = 32;
    localparam int ACTIVE_BITS   = 5;

    typedef struct packed {
        logic match;     // entry point equals the point being checked
        logic skipping;  // entry still in its skip phase
    } frtt_eval_t;

endpackage

`default_nettype wire

// File: src/frtt_rule_mem.sv
// rule storage: one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module frtt_rule_mem #(
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = 4,
    parameter int WIDTH     = 104
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/frtt_match_unit.sv
// shared match unit: point compare, skip phase compare and saturating hit increment
// depends on frtt_pkg
`timescale 1ns / 1ps
`default_nettype none

module frtt_match_unit #(
    parameter int POINT_BITS = 8,
    parameter int COUNT_BITS = 32
) (
    input  wire logic [POINT_BITS-1:0] check_point,
    input  wire logic [POINT_BITS-1:0] entry_point,
    input  wire logic [COUNT_BITS-1:0] entry_skip,
    input  wire logic [COUNT_BITS-1:0] entry_hit,
    output frtt_pkg::frtt_eval_t       flags,
    output logic      [COUNT_BITS-1:0] hit_next
);

    import frtt_pkg::*;

    always_comb begin
        flags.match    = (entry_point == check_point);
        flags.skipping = (entry_hit < entry_skip);
        // saturate at the top of the counter
        hit_next = (&entry_hit) ? entry_hit : entry_hit + COUNT_BITS'(1);
    end

endmodule

`default_nettype wire

// File: src/fault_rule_trigger_table_core.sv
// Fault rule trigger table: stream ports, sequencer, rule memory and shared match unit.
// Depends on frtt_pkg, frtt_rule_mem and frtt_match_unit.
//
// Usage: one input word per operation on the s_axis channel, one result word per
// operation on the m_axis channel. s_axis_tuser carries the operation: register
// appends a rule, clear empties the table and zeroes the trigger total, check
// scans the rules for the given point. Every result carries fail, status, the
// trigger total and the number of rules in the table after the operation.
// Sequence: register, clear and unused codes pass from idle to the response state,
// which loads the result register. A check reads one rule at a time in the evaluate
// state, then passes through the fire state when a rule fires and through the move
// state when a fired rule is retired by moving the last rule into its slot, before
// the response state. The scan is set by the single registered read port of the rule
// memory feeding the match unit, one rule a cycle.
// s_axis_tready is high only while the sequencer is idle; one operation is worked on
// at a time. A result waits in the output register while m_axis_tready is low; the
// next operation may be accepted meanwhile and its result then holds until the
// register frees. Reset empties the table and zeroes the trigger total at once;
// rule memory contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module fault_rule_trigger_table_core #(
    parameter int RULES      = frtt_pkg::RULES_DEF,
    parameter int POINT_BITS = frtt_pkg::POINT_BITS_DEF,
    parameter int COUNT_BITS = frtt_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // point [7:0], skip [39:8], limit [71:40]
    input  wire logic [frtt_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // func [1:0]
    input  wire logic [1:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // fail [0], status [1], trigger total [33:2], rule count [38:34], zero [39]
    output logic      [frtt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    import frtt_pkg::*;

    localparam int IDX_BITS   = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_BITS   = $clog2(RULES + 1);
    localparam int ENTRY_BITS = POINT_BITS + 3 * COUNT_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_FIRE = 3'd2;
    localparam logic [2:0] ST_MOVE = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [TOTAL_BITS-1:0] trig_reg, trig_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [POINT_BITS-1:0] pt_reg, pt_next;
    logic                  fail_reg, fail_next;
    logic                  status_reg, status_next;
    logic [COUNT_BITS-1:0] fire_hit_reg, fire_hit_next;
    logic [COUNT_BITS-1:0] fire_skip_reg, fire_skip_next;
    logic [COUNT_BITS-1:0] fire_limit_reg, fire_limit_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic                  mem_we, mem_re;
    logic [IDX_BITS-1:0]   mem_waddr, mem_raddr;
    logic [ENTRY_BITS-1:0] mem_wdata, mem_rdata;

    logic [POINT_BITS-1:0] rd_point;
    logic [COUNT_BITS-1:0] rd_skip, rd_limit, rd_hit, hit_next;
    frtt_eval_t            flags;

    logic [POINT_BITS-1:0] in_point;
    logic [IDX_BITS-1:0]   last_idx;
    logic                  more_rules;
    logic                  retire;
    logic                  accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    assign in_point = POINT_BITS'(s_axis_tdata[7:0]);
    assign {rd_point, rd_skip, rd_limit, rd_hit} = mem_rdata;
    assign last_idx   = IDX_BITS'(count_reg - CNT_BITS'(1));
    assign more_rules = (CNT_BITS'(idx_reg) + CNT_BITS'(1)) < count_reg;
    // fired rule has used up its firing budget
    assign retire = (fire_limit_reg != '0) &&
                    ((fire_hit_reg - fire_skip_reg) >= fire_limit_reg);

    frtt_rule_mem #(
        .DEPTH     (RULES),
        .ADDR_BITS (IDX_BITS),
        .WIDTH     (ENTRY_BITS)
    ) u_rule_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    frtt_match_unit #(
        .POINT_BITS (POINT_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_match_unit (
        .check_point (pt_reg),
        .entry_point (rd_point),
        .entry_skip  (rd_skip),
        .entry_hit   (rd_hit),
        .flags       (flags),
        .hit_next    (hit_next)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        trig_next       = trig_reg;
        idx_next        = idx_reg;
        pt_next         = pt_reg;
        fail_next       = fail_reg;
        status_next     = status_reg;
        fire_hit_next   = fire_hit_reg;
        fire_skip_next  = fire_skip_reg;
        fire_limit_next = fire_limit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_axis_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    fail_next   = 1'b0;
                    status_next = 1'b0;
                    state_next  = ST_RESP;
                    case (s_axis_tuser)
                        FUNC_REGISTER: begin
                            if (count_reg >= CNT_BITS'(RULES)) begin
                                status_next = 1'b1;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_BITS-1:0];
                                mem_wdata  = {in_point,
                                              COUNT_BITS'(s_axis_tdata[39:8]),
                                              COUNT_BITS'(s_axis_tdata[71:40]),
                                              {COUNT_BITS{1'b0}}};
                                count_next = count_reg + CNT_BITS'(1);
                            end
                        end
                        FUNC_CLEAR: begin
                            count_next = '0;
                            trig_next  = '0;
                        end
                        FUNC_CHECK: begin
                            pt_next = in_point;
                            if (count_reg != '0) begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = ST_EVAL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                if (flags.match) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = {rd_point, rd_skip, rd_limit, hit_next};
                end
                if (flags.match && !flags.skipping) begin
                    fire_hit_next   = hit_next;
                    fire_skip_next  = rd_skip;
                    fire_limit_next = rd_limit;
                    trig_next       = trig_reg + TOTAL_BITS'(1);
                    fail_next       = 1'b1;
                    state_next      = ST_FIRE;
                end else if (more_rules) begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + IDX_BITS'(1);
                    idx_next  = idx_reg + IDX_BITS'(1);
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_FIRE: begin
                state_next = ST_RESP;
                if (retire) begin
                    count_next = count_reg - CNT_BITS'(1);
                    if (idx_reg != last_idx) begin
                        // fetch the last rule to fill the gap
                        mem_re     = 1'b1;
                        mem_raddr  = last_idx;
                        state_next = ST_MOVE;
                    end
                end
            end
            ST_MOVE: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = mem_rdata;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, ACTIVE_BITS'(count_reg), trig_reg,
                                     status_reg, fail_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            trig_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            trig_reg     <= trig_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        pt_reg         <= pt_next;
        fail_reg       <= fail_next;
        status_reg     <= status_next;
        fire_hit_reg   <= fire_hit_next;
        fire_skip_reg  <= fire_skip_next;
        fire_limit_reg <= fire_limit_next;
        m_tdata_reg    <= m_tdata_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(RULES))
        else $error("rule count beyond table size");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tuser == FUNC_CLEAR) |=> (count_reg == '0 && trig_reg == '0))
        else $error("clear did not empty the table");

    a_register_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tuser == FUNC_REGISTER && count_reg < CNT_BITS'(RULES))
        |=> (count_reg == $past(count_reg) + CNT_BITS'(1)))
        else $error("register did not append a rule");

    a_scan_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (CNT_BITS'(idx_reg) < count_reg))
        else $error("scan index past the last rule");

    a_move_after_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE) |-> ($past(state_reg) == ST_FIRE))
        else $error("rule move without a retiring fire");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench for fault_rule_trigger_table_core: register, clear, check and unused
// operations, predicted by an in-bench mirror of the rule table. needs frtt_pkg and the core
`timescale 1ns / 1ps

module tb_top;
    import frtt_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         TABLE_SIZE  = RULES_DEF;
    localparam int         STALL_LIMIT = 2000;
    localparam int         RANDOM_OPS  = 1500;

    typedef struct {
        logic        fail;
        logic        status;
        logic [31:0] total;
        logic [4:0]  active;
    } outcome_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG_STALL
    } rx_mode_t;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;   // point, skip, limit
    logic [1:0]               s_axis_tuser  = '0;   // func
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;         // fail, status, total, active, zero

    // mirror of the rule table
    logic [7:0]  point_mirror [TABLE_SIZE];
    logic [31:0] skip_mirror  [TABLE_SIZE];
    logic [31:0] limit_mirror [TABLE_SIZE];
    logic [31:0] hits_mirror  [TABLE_SIZE];
    int          rule_cnt  = 0;
    logic [31:0] trig_cnt  = '0;

    outcome_t    outcome_q[$];
    int unsigned err_cnt     = 0;
    int unsigned ops_sent    = 0;
    int unsigned fires_seen  = 0;
    int unsigned retires     = 0;
    int unsigned refusals    = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;

    rx_mode_t    rx_mode      = RX_OPEN;
    int unsigned rx_mode_left = 0;
    logic [7:0]  rx_tick      = '0;

    fault_rule_trigger_table_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // works out the outcome of one operation and updates the mirror
    task automatic apply_table_op(input logic [1:0] func, input logic [7:0] point,
                                  input logic [31:0] skip, input logic [31:0] hits,
                                  output outcome_t res);
        int   i;
        int   last;
        logic fired;
        fired      = 1'b0;
        res.status = 1'b0;
        case (func)
            FUNC_REGISTER: begin
                if (rule_cnt >= TABLE_SIZE) begin
                    res.status = 1'b1;
                    refusals++;
                end else begin
                    point_mirror[rule_cnt] = point;
                    skip_mirror[rule_cnt]  = skip;
                    limit_mirror[rule_cnt] = hits;
                    hits_mirror[rule_cnt]  = '0;
                    rule_cnt++;
                end
            end
            FUNC_CLEAR: begin
                rule_cnt = 0;
                trig_cnt = '0;
            end
            FUNC_CHECK: begin
                for (i = 0; i < rule_cnt && !fired; i++) begin
                    if (point_mirror[i] == point) begin
                        if (hits_mirror[i] < skip_mirror[i]) begin
                            hits_mirror[i] = hits_mirror[i] + 1;
                        end else begin
                            // hit counter saturates at all ones
                            if (hits_mirror[i] != 32'hFFFF_FFFF)
                                hits_mirror[i] = hits_mirror[i] + 1;
                            trig_cnt = trig_cnt + 1;
                            fired    = 1'b1;
                            fires_seen++;
                            if (limit_mirror[i] != 0 &&
                                hits_mirror[i] - skip_mirror[i] >= limit_mirror[i]) begin
                                // retire: last rule moves into this slot
                                last            = rule_cnt - 1;
                                point_mirror[i] = point_mirror[last];
                                skip_mirror[i]  = skip_mirror[last];
                                limit_mirror[i] = limit_mirror[last];
                                hits_mirror[i]  = hits_mirror[last];
                                rule_cnt        = last;
                                retires++;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        res.fail   = fired;
        res.total  = trig_cnt;
        res.active = rule_cnt[4:0];
    endtask

    // sends one word in bursts with random gaps, then records its outcome
    task automatic send_op(input logic [1:0] func, input logic [7:0] point,
                           input logic [31:0] skip, input logic [31:0] hits);
        int unsigned gap;
        outcome_t    res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hits, skip, point};
        s_axis_tuser  <= func;
        do @(posedge aclk); while (!s_axis_tready);
        apply_table_op(func, point, skip, hits, res);
        outcome_q.push_back(res);
        if (func != FUNC_UNUSED)
            ops_sent++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %h",
                         $time, m_axis_tdata);
                err_cnt++;
            end else begin
                want = outcome_q.pop_front();
                check_field("fail", 32'(want.fail), 32'(m_axis_tdata[0]));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[1]));
                check_field("trigger total", want.total, m_axis_tdata[33:2]);
                check_field("rule count", 32'(want.active), 32'(m_axis_tdata[38:34]));
                check_field("pad bit", '0, 32'(m_axis_tdata[39]));
            end
        end
    end

    // receiver back-pressure, switching at random among open, random, periodic and long stall patterns
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_tick <= rx_tick + 8'd1;
        case (rx_mode)
            RX_OPEN:       m_axis_tready <= 1'b1;
            RX_RANDOM:     m_axis_tready <= ($urandom_range(0, 2) != 0);
            RX_PERIODIC:   m_axis_tready <= (rx_tick % 5 != 0);
            RX_LONG_STALL: m_axis_tready <= rx_tick[4];
            default:       m_axis_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] count_value();
        // mostly small so rules fire and retire, sometimes full range
        return ($urandom_range(0, 4) != 0) ? 32'($urandom_range(0, 3)) : 32'($urandom);
    endfunction

    task automatic test_empty_and_unused();
        send_op(FUNC_CHECK, 8'h00, '0, '0);
        send_op(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_skip_and_retire();
        send_op(FUNC_REGISTER, 8'h05, 32'd1, 32'd1);
        send_op(FUNC_CHECK, 8'h05, '0, '0);        // still skipping
        send_op(FUNC_CHECK, 8'h05, '0, '0);        // fires and retires
        send_op(FUNC_REGISTER, 8'h09, 32'd5, 32'd1);
        send_op(FUNC_REGISTER, 8'h00, 32'd0, 32'd0);
        send_op(FUNC_REGISTER, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_REGISTER, 8'h09, 32'd0, 32'd1);
        send_op(FUNC_CHECK, 8'h09, '0, '0);        // first skips, second fires
        send_op(FUNC_CHECK, 8'h00, '0, '0);        // unlimited rule
        send_op(FUNC_CHECK, 8'h00, '0, '0);
        send_op(FUNC_CHECK, 8'hFF, '0, '0);
        send_op(FUNC_CHECK, 8'h77, '0, '0);        // no match
    endtask

    task automatic test_fill_and_refuse();
        while (rule_cnt < TABLE_SIZE)
            send_op(FUNC_REGISTER, 8'($urandom), 32'($urandom_range(0, 2)), 32'd1);
        send_op(FUNC_REGISTER, 8'hA5, 32'd0, 32'd0);
        send_op(FUNC_CLEAR, 8'h00, '0, '0);
    endtask

    task automatic test_random_traffic();
        logic [7:0]  spot [4];
        int unsigned regs;
        int unsigned checks;
        int unsigned k;
        while (ops_sent < RANDOM_OPS) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: anything the fields allow
                send_op(2'($urandom_range(0, 3)), 8'($urandom), 32'($urandom), 32'($urandom));
            end else begin
                for (k = 0; k < 4; k++)
                    spot[k] = 8'($urandom);
                if ($urandom_range(0, 2) == 0)
                    send_op(FUNC_CLEAR, 8'($urandom), 32'($urandom), 32'($urandom));
                regs = $urandom_range(1, 18);
                for (k = 0; k < regs; k++)
                    send_op(FUNC_REGISTER, spot[$urandom_range(0, 3)], count_value(),
                            count_value());
                checks = $urandom_range(4, 40);
                for (k = 0; k < checks; k++)
                    send_op(FUNC_CHECK,
                            ($urandom_range(0, 7) != 0) ? spot[$urandom_range(0, 3)]
                                                        : 8'($urandom),
                            32'($urandom), 32'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_unused();
        test_skip_and_retire();
        test_fill_and_refuse();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (TABLE_SIZE + 8) @(posedge aclk);
        $display("covered %0d operations: %0d faults fired, %0d rules retired,", ops_sent,
                 fires_seen, retires);
        $display("%0d registers refused on a full table, %0d mismatches", refusals, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/frtt_pkg.sv
src/frtt_rule_mem.sv
src/frtt_match_unit.sv
src/fault_rule_trigger_table_core.sv
test/tb_top.sv
